>>> rtl/ctbw_pkg.sv
// Shared types and constants for the compact-target work block.
`default_nettype none
package ctbw_pkg;

	localparam int unsigned BITS_W  = 32;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned NUM_W   = 256;
	localparam int unsigned STEP_W  = 8;

	// Status codes on the result
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture the request word
		logic decode;  // expand the target, set up the divider
		logic step;    // one restoring-division step
		logic emit;    // present one result word, advance to the next
	} ctbw_cmd_t;

endpackage
`default_nettype wire

>>> rtl/ctbw_dpath.sv
// Datapath: compact decode, bit-serial 256-bit divider and word output.
`default_nettype none
module ctbw_dpath
	import ctbw_pkg::*;
(
	input  wire logic              clk,
	input  wire ctbw_cmd_t         cmd,
	input  wire logic [BITS_W-1:0] compact_bits,
	output logic      [WORD_W-1:0] work_word,
	output logic      [1:0]        status
);

	logic [BITS_W-1:0] bits_q;
	logic [NUM_W-1:0]  t_q;
	logic [NUM_W-1:0]  rq_q;    // dividend bits going out, quotient bits coming in
	logic [NUM_W-1:0]  rem_q;
	logic [1:0]        status_q;
	logic              carry_q;

	logic [7:0]        size;
	logic [22:0]       mraw;
	logic [22:0]       mant;
	logic [7:0]        size_m3;
	logic [4:0]        sh_bytes;
	logic [NUM_W-1:0]  target;
	logic              negative;
	logic              overflow;
	logic [1:0]        status_d;
	logic [NUM_W:0]    shifted;
	logic [NUM_W+1:0]  diff;
	logic              ge;
	logic [WORD_W:0]   sum;

	// Decode the compact word
	always_comb begin
		size     = bits_q[31:24];
		mraw     = bits_q[22:0];
		size_m3  = size - 8'd3;
		sh_bytes = size_m3[4:0];
		case (size)
			8'd0:    mant = 23'd0;
			8'd1:    mant = {16'd0, mraw[22:16]};
			8'd2:    mant = {8'd0, mraw[22:8]};
			default: mant = mraw;
		endcase
		negative = (mant != 23'd0) && bits_q[23];
		overflow = (mant != 23'd0) && ((size > 8'd34) ||
			((mant > 23'h0000ff) && (size > 8'd33)) ||
			((mant > 23'h00ffff) && (size > 8'd32)));
		if (size <= 8'd3) begin
			target = {{(NUM_W-23){1'b0}}, mant};
		end else begin
			target = {{(NUM_W-23){1'b0}}, mant} << {sh_bytes, 3'b000};
		end
		if (negative || overflow) begin
			status_d = ST_BAD;
		end else if (mant == 23'd0) begin
			status_d = ST_ZERO;
		end else begin
			status_d = ST_OK;
		end
	end

	// Division step: remainder >= T+1 tested as (shifted - T - 1) without borrow
	always_comb begin
		shifted = {rem_q, rq_q[NUM_W-1]};
		diff    = {1'b0, shifted} - {2'b00, t_q} - {{(NUM_W+1){1'b0}}, 1'b1};
		ge      = !diff[NUM_W+1];
	end

	// Output word plus the final +1 carried word by word
	always_comb begin
		sum       = {1'b0, rq_q[WORD_W-1:0]} + {{WORD_W{1'b0}}, carry_q};
		work_word = (status_q == ST_OK) ? sum[WORD_W-1:0] : '0;
		status    = status_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bits_q <= compact_bits;
		end
		if (cmd.decode) begin
			t_q      <= target;
			rq_q     <= ~target;
			rem_q    <= '0;
			status_q <= status_d;
			carry_q  <= 1'b1;
		end else if (cmd.step) begin
			rem_q <= ge ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];
			rq_q  <= {rq_q[NUM_W-2:0], ge};
		end else if (cmd.emit) begin
			rq_q    <= rq_q >> WORD_W;
			carry_q <= sum[WORD_W];
		end
	end

endmodule
`default_nettype wire

>>> rtl/ctbw_ctrl.sv
// Controller: sequences decode, 256 division steps and four result words.
`default_nettype none
module ctbw_ctrl
	import ctbw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	output logic       done,
	output logic [1:0] word_index,
	output logic       last,
	output ctbw_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_DIV    = 4'b0100,
		S_OUT    = 4'b1000
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
					end
					cnt_q <= '0;
				end
				S_DECODE: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == {STEP_W{1'b1}}) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands and result marks
	always_comb begin
		busy       = (state_q != S_IDLE);
		cmd.load   = start && (state_q == S_IDLE);
		cmd.decode = (state_q == S_DECODE);
		cmd.step   = (state_q == S_DIV);
		cmd.emit   = (state_q == S_OUT);
		done       = (state_q == S_OUT);
		word_index = cnt_q[1:0];
		last       = done && (cnt_q[1:0] == 2'd3);
	end

	a_req_takes: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("request accepted but block not busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");
	a_last_free: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |=> !busy)
		else $error("block still busy after final word");
	a_free_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done && last))
		else $error("block went idle without final word");
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) |-> word_index == $past(word_index) + 2'd1)
		else $error("result words out of order");

endmodule
`default_nettype wire

>>> rtl/compact_target_block_work.sv
// Top level of the compact-target block work calculator.
`default_nettype none
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   compact_bits is sampled then. The block decodes the compact target T and
//   computes floor(2^256/(T+1)) by restoring division, one quotient bit per
//   cycle in a shared 256-bit subtract/compare unit.
//   Results: four words, least significant first, each shown for exactly one
//   cycle with done high; word_index gives the position, last marks the
//   fourth word, status is 0 ok, 1 negative/overflowing, 2 zero target.
//   Work words are zero whenever status is nonzero.
//   Sequence: a decode state, the division loop, then the four output words;
//   busy stays high throughout and drops after the fourth word, so the block
//   takes no new request until the previous one has finished.
//   The receiver cannot stall; results are simply presented in order.
//   Reset (arst_n low) returns the controller to idle; any request in
//   progress is dropped.
module compact_target_block_work
	import ctbw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [BITS_W-1:0] compact_bits,
	output logic                   done,
	output logic      [WORD_W-1:0] work_word,
	output logic      [1:0]        word_index,
	output logic      [1:0]        status,
	output logic                   last
);

	ctbw_cmd_t cmd;

	ctbw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.done       (done),
		.word_index (word_index),
		.last       (last),
		.cmd        (cmd)
	);

	ctbw_dpath u_dpath (
		.clk          (clk),
		.cmd          (cmd),
		.compact_bits (compact_bits),
		.work_word    (work_word),
		.status       (status)
	);

endmodule
`default_nettype wire

>>> tb/compact_target_block_work_tb.sv
// Self-checking testbench for the compact-target block work calculator.
`timescale 1ns / 1ps
`default_nettype none
module compact_target_block_work_tb
	import ctbw_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam int unsigned RANDOM_REQS = 186;
	localparam int unsigned NUM_DIRECTED = 24;

	// One expected result word
	typedef struct packed {
		logic [WORD_W-1:0] work;
		logic [1:0]        idx;
		logic [1:0]        st;
		logic              lst;
	} work_word_t;

	// One directed request; typed rows carry their result, others go to the predictor
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic              typed;
		logic [1:0]        st;
		logic [NUM_W-1:0]  work;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [BITS_W-1:0] compact_bits = '0;
	logic              busy;
	logic              done;
	logic [WORD_W-1:0] work_word;
	logic [1:0]        word_index;
	logic [1:0]        status;
	logic              last;

	work_word_t  pending_words[$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	// Extremes, every status, and the corner cases of the compact decode
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{32'h0000_0000, 1'b1, ST_ZERO, '0},
		'{32'h0300_0001, 1'b1, ST_OK, {1'b1, 255'b0}},  // T = 1: work is 2^255
		'{32'h0380_0001, 1'b1, ST_BAD, '0},             // negative
		'{32'h0380_0000, 1'b1, ST_ZERO, '0},            // sign with zero mantissa
		'{32'h2300_0001, 1'b1, ST_BAD, '0},             // exponent too large
		'{32'h2200_0100, 1'b1, ST_BAD, '0},             // two bytes at exponent 34
		'{32'h2200_00ff, 1'b0, ST_OK, '0},
		'{32'h2101_0000, 1'b1, ST_BAD, '0},             // three bytes at exponent 33
		'{32'h2100_ffff, 1'b0, ST_OK, '0},
		'{32'h207f_ffff, 1'b0, ST_OK, '0},
		'{32'h2080_0000, 1'b1, ST_ZERO, '0},
		'{32'hff7f_ffff, 1'b1, ST_BAD, '0},
		'{32'hffff_ffff, 1'b1, ST_BAD, '0},             // negative and overflowing
		'{32'hff00_0000, 1'b1, ST_ZERO, '0},
		'{32'h0100_3456, 1'b1, ST_ZERO, '0},            // mantissa shifted out
		'{32'h0112_0000, 1'b0, ST_OK, '0},
		'{32'h0212_3400, 1'b0, ST_OK, '0},
		'{32'h1d00_ffff, 1'b0, ST_OK, '0},
		'{32'h037f_ffff, 1'b0, ST_OK, '0},
		'{32'h0080_0000, 1'b1, ST_ZERO, '0},
		'{32'h00ff_ffff, 1'b1, ST_ZERO, '0},
		'{32'h0400_0001, 1'b0, ST_OK, '0},
		'{32'h2280_0001, 1'b1, ST_BAD, '0},
		'{32'h2200_0001, 1'b0, ST_OK, '0}
	};

	compact_target_block_work dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.compact_bits (compact_bits),
		.done         (done),
		.work_word    (work_word),
		.word_index   (word_index),
		.status       (status),
		.last         (last)
	);

	always #1 clk = ~clk;

	// Decode the compact target and compute floor(2^256 / (T + 1))
	function automatic void predict_work(input logic [BITS_W-1:0] bits,
			output logic [1:0] st, output logic [NUM_W-1:0] work);
		logic [7:0]       expo;
		logic [22:0]      mant;
		logic             neg;
		logic             ovf;
		logic [NUM_W-1:0] target;
		expo = bits[31:24];
		mant = bits[22:0];
		if (expo <= 8'd3)
			mant = mant >> (8 * (3 - expo));
		neg = (mant != 0) && bits[23];
		ovf = (mant != 0) && ((expo > 8'd34) || (mant > 23'hff && expo > 8'd33) ||
			(mant > 23'hffff && expo > 8'd32));
		work = '0;
		if (neg || ovf) begin
			st = ST_BAD;
		end else if (mant == 0) begin
			st = ST_ZERO;
		end else begin
			st = ST_OK;
			target = NUM_W'(mant);
			if (expo > 8'd3)
				target = target << (8 * (expo - 3));
			work = (~target) / (target + 1'b1) + 1'b1;
		end
	endfunction

	// Split a work value into its four result words
	task automatic queue_work(input logic [1:0] st, input logic [NUM_W-1:0] work);
		work_word_t w;
		for (int i = 0; i < 4; i++) begin
			w.work = work[WORD_W*i +: WORD_W];
			w.idx  = 2'(i);
			w.st   = st;
			w.lst  = (i == 3);
			pending_words = {pending_words, w};
		end
	endtask

	// Present a request and hold it until the block takes it
	task automatic issue_request(input directed_row_t row);
		logic [1:0]       st;
		logic [NUM_W-1:0] work;
		start <= 1'b1;
		compact_bits <= row.bits;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (row.typed) begin
			queue_work(row.st, row.work);
		end else begin
			predict_work(row.bits, st, work);
			queue_work(st, work);
		end
	endtask

	// Mostly well-formed targets with random content, some raw noise
	function automatic logic [BITS_W-1:0] random_compact();
		logic [7:0]  expo;
		logic        sgn;
		logic [22:0] mant;
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		expo = 8'($urandom_range(0, 36));
		sgn  = ($urandom_range(0, 9) == 0);
		mant = 23'($urandom());
		case ($urandom_range(0, 9)) inside
			0: mant = '0;
			[1:2]: mant = mant & 23'hff;
			[3:4]: mant = mant & 23'hffff;
			default: ;
		endcase
		return {expo, sgn, mant};
	endfunction

	// Result checker; the block never holds results back
	always @(posedge clk) begin
		work_word_t w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				$error("result word with no request pending: index %0d", word_index);
				fail_count++;
			end else begin
				w = pending_words.pop_front();
				if (work_word !== w.work) begin
					$error("work_word: expected %h, got %h", w.work, work_word);
					fail_count++;
				end
				if (word_index !== w.idx) begin
					$error("word_index: expected %0d, got %0d", w.idx, word_index);
					fail_count++;
				end
				if (status !== w.st) begin
					$error("status: expected %0d, got %0d", w.st, status);
					fail_count++;
				end
				if (last !== w.lst) begin
					$error("last: expected %0b, got %0b", w.lst, last);
					fail_count++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus
	initial begin
		directed_row_t row;
		int unsigned   burst;
		int unsigned   gap;
		int unsigned   drain;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests back to back
		for (int i = 0; i < NUM_DIRECTED; i++)
			issue_request(directed_rows[i]);
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		@(posedge clk);

		// random requests in bursts with random gaps
		burst = 0;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			row.bits  = random_compact();
			row.typed = 1'b0;
			row.st    = ST_OK;
			row.work  = '0;
			issue_request(row);
			if (n == RANDOM_REQS / 2) begin
				// let the block drain completely once mid-run
				start <= 1'b0;
				while (pending_words.size() != 0)
					@(posedge clk);
				@(posedge clk);
				burst = 0;
			end else if (burst == 0) begin
				burst = $urandom_range(1, 6);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst--;
			end
		end
		start <= 1'b0;

		// wait out the last request, then let the clock run idle before reporting
		drain = 0;
		while (pending_words.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (pending_words.size() != 0) begin
			$error("%0d result words never arrived", pending_words.size());
			fail_count++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
rtl/ctbw_pkg.sv
rtl/ctbw_dpath.sv
rtl/ctbw_ctrl.sv
rtl/compact_target_block_work.sv
tb/compact_target_block_work_tb.sv
